// ----- sv/ssr_pkg.sv -----
// Shared constants, step codes and command/status types for the statistics reducer.
package ssr_pkg;

  localparam logic [12:0] MAX_COUNT = 13'd4096;

  localparam int ACC_W = 56;
  localparam int OPB_W = 28;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [3:0] STEP_MEAN = 4'd0;
  localparam logic [3:0] STEP_MSQ  = 4'd1;
  localparam logic [3:0] STEP_RMS  = 4'd2;
  localparam logic [3:0] STEP_NSQ  = 4'd3;
  localparam logic [3:0] STEP_SS   = 4'd4;
  localparam logic [3:0] STEP_NN   = 4'd5;
  localparam logic [3:0] STEP_GS   = 4'd6;
  localparam logic [3:0] STEP_GG   = 4'd7;
  localparam logic [3:0] STEP_NGG  = 4'd8;
  localparam logic [3:0] STEP_NUM  = 4'd9;
  localparam logic [3:0] STEP_VDIV = 4'd10;
  localparam logic [3:0] STEP_VSQ  = 4'd11;
  localparam logic [3:0] STEP_END  = 4'd12;

  typedef struct packed {
    logic       accept;
    logic       start;
    logic       capture;
    logic       load_out;
    logic [3:0] step;
  } ssr_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic mode;
  } ssr_sts_t;

  function automatic logic [3:0] next_step(input logic [3:0] step, input logic mode);
    logic [3:0] nxt;
    unique case (step)
      STEP_MEAN: nxt = STEP_MSQ;
      STEP_MSQ:  nxt = STEP_RMS;
      STEP_RMS:  nxt = mode ? STEP_GS : STEP_NSQ;
      STEP_NSQ:  nxt = STEP_SS;
      STEP_SS:   nxt = STEP_NN;
      STEP_NN:   nxt = STEP_NUM;
      STEP_GS:   nxt = STEP_GG;
      STEP_GG:   nxt = STEP_NGG;
      STEP_NGG:  nxt = STEP_NUM;
      STEP_NUM:  nxt = STEP_VDIV;
      STEP_VDIV: nxt = STEP_VSQ;
      default:   nxt = STEP_END;
    endcase
    return nxt;
  endfunction

endpackage

// ----- sv/ssr_iter.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
module ssr_iter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 op,
  input  logic [ssr_pkg::ACC_W-1:0]  a,
  input  logic [ssr_pkg::OPB_W-1:0]  b,
  output logic                       done,
  output logic [ssr_pkg::ACC_W-1:0]  res
);
  import ssr_pkg::*;

  logic              busy;
  logic [5:0]        cnt;
  logic [1:0]        opr;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  m;
  logic [ACC_W-1:0]  q;
  logic [28:0]       rem;
  logic [OPB_W-1:0]  dvs;
  logic [5:0]        last_cnt;
  logic [28:0]       dt;
  logic [28:0]       st;
  logic [28:0]       trial;

  always_comb begin
    unique case (opr)
      OP_MUL:  last_cnt = 6'd27;
      OP_DIV:  last_cnt = 6'd55;
      default: last_cnt = 6'd15;
    endcase
    dt    = {rem[27:0], q[ACC_W-1]};
    st    = {rem[26:0], q[ACC_W-1:ACC_W-2]};
    trial = {11'd0, acc[15:0], 2'b01};
  end

  assign res = (opr == OP_DIV) ? q : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      opr  <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        opr  <= op;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      unique case (op)
        OP_MUL: begin
          acc <= '0;
          m   <= a;
          q   <= {{(ACC_W-OPB_W){1'b0}}, b};
        end
        OP_DIV: begin
          q   <= a;
          rem <= '0;
          dvs <= b;
        end
        default: begin
          q   <= {a[31:0], {(ACC_W-32){1'b0}}};
          acc <= '0;
          rem <= '0;
        end
      endcase
    end else if (busy) begin
      unique case (opr)
        OP_MUL: begin
          if (q[0]) acc <= acc + m;
          m <= {m[ACC_W-2:0], 1'b0};
          q <= {1'b0, q[ACC_W-1:1]};
        end
        OP_DIV: begin
          if (dt >= {1'b0, dvs}) begin
            rem <= dt - {1'b0, dvs};
            q   <= {q[ACC_W-2:0], 1'b1};
          end else begin
            rem <= dt;
            q   <= {q[ACC_W-2:0], 1'b0};
          end
        end
        default: begin
          if (st >= trial) begin
            rem <= st - trial;
            acc <= {acc[ACC_W-2:0], 1'b1};
          end else begin
            rem <= st;
            acc <= {acc[ACC_W-2:0], 1'b0};
          end
          q <= {q[ACC_W-3:0], 2'b00};
        end
      endcase
    end
  end

endmodule

// ----- sv/ssr_ctrl.sv -----
// Controller: accumulate phase, finalize step sequencer, result register handshake.
module ssr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_element,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ssr_pkg::ssr_sts_t sts,
  output ssr_pkg::ssr_cmd_t cmd
);
  import ssr_pkg::*;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] step, step_next;
  logic       out_valid_next;
  logic [3:0] nstep;

  assign nstep = next_step(step, sts.mode);

  always_comb begin
    cmd            = '0;
    cmd.step       = step;
    state_next     = state;
    step_next      = step;
    in_ready       = 1'b0;
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (last_element) begin
            state_next = ST_RUN;
            step_next  = STEP_MEAN;
          end
        end
      end
      ST_RUN: begin
        if (step == STEP_NUM) begin
          cmd.capture = 1'b1;
          step_next   = nstep;
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.iter_done) begin
          cmd.capture = 1'b1;
          step_next   = nstep;
          state_next  = (nstep == STEP_END) ? ST_OUT : ST_RUN;
        end
      end
      default: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_ACC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      step      <= STEP_MEAN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/ssr_dp.sv -----
// Datapath: running accumulators, config registers, finalize operands, result registers.
module ssr_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  ssr_pkg::ssr_cmd_t        cmd,
  output ssr_pkg::ssr_sts_t        sts,
  input  logic signed [15:0]       sample,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [15:0]              cfg_data,
  output logic signed [27:0]       sum_total,
  output logic signed [15:0]       mean_value,
  output logic [31:0]              variance_value,
  output logic [15:0]              std_dev,
  output logic [15:0]              rms_value,
  output logic signed [15:0]       min_value,
  output logic [11:0]              min_position,
  output logic signed [15:0]       max_value,
  output logic [11:0]              max_position,
  output logic                     all_zero,
  output logic [12:0]              element_count,
  output logic                     overflow
);
  import ssr_pkg::*;

  localparam logic CFG_MEAN_SOURCE = 1'b0;
  localparam logic CFG_GIVEN_MEAN  = 1'b1;

  logic               mean_source;
  logic signed [15:0] given_mean;

  logic signed [27:0] run_sum;
  logic [42:0]        run_sq;
  logic signed [15:0] lo_val, hi_val;
  logic [11:0]        lo_idx, hi_idx;
  logic [12:0]        cnt;
  logic               nz;
  logic               ovf;

  logic [15:0]        mean_r, rms_r, std_r;
  logic [31:0]        msq_r, var_r, nn_r;
  logic [ACC_W-1:0]   t1, t2, num;

  logic [1:0]         op;
  logic [ACC_W-1:0]   opa;
  logic [OPB_W-1:0]   opb;
  logic               done;
  logic [ACC_W-1:0]   res;

  logic [27:0]        abs_s;
  logic [15:0]        abs_g;
  logic [31:0]        sq_x;
  logic [57:0]        pos, tw, t1w, t2w, num_w;

  assign sts.iter_done = done;
  assign sts.mode      = mean_source;

  always_comb begin
    abs_s = run_sum[27] ? (~run_sum + 28'd1) : run_sum;
    abs_g = given_mean[15] ? (~given_mean + 16'd1) : given_mean;
    sq_x  = 32'(sample * sample);
    t1w   = {2'b0, t1};
    t2w   = {2'b0, t2};
    pos   = {15'b0, run_sq} + {2'b0, t1};
    tw    = {1'b0, t2, 1'b0};
    if (!mean_source) begin
      num_w = (t1w >= t2w) ? (t1w - t2w) : '0;
    end else if (given_mean[15] ^ run_sum[27]) begin
      num_w = pos + tw;
    end else begin
      num_w = (pos >= tw) ? (pos - tw) : '0;
    end
  end

  always_comb begin
    op  = OP_MUL;
    opa = '0;
    opb = '0;
    unique case (cmd.step)
      STEP_MEAN: begin op = OP_DIV;  opa = ACC_W'(abs_s);  opb = OPB_W'(cnt);   end
      STEP_MSQ:  begin op = OP_DIV;  opa = ACC_W'(run_sq); opb = OPB_W'(cnt);   end
      STEP_RMS:  begin op = OP_SQRT; opa = ACC_W'(msq_r);                       end
      STEP_NSQ:  begin op = OP_MUL;  opa = ACC_W'(run_sq); opb = OPB_W'(cnt);   end
      STEP_SS:   begin op = OP_MUL;  opa = ACC_W'(abs_s);  opb = abs_s;         end
      STEP_NN:   begin op = OP_MUL;  opa = ACC_W'(cnt);    opb = OPB_W'(cnt);   end
      STEP_GS:   begin op = OP_MUL;  opa = ACC_W'(abs_s);  opb = OPB_W'(abs_g); end
      STEP_GG:   begin op = OP_MUL;  opa = ACC_W'(abs_g);  opb = OPB_W'(abs_g); end
      STEP_NGG:  begin op = OP_MUL;  opa = ACC_W'(nn_r);   opb = OPB_W'(cnt);   end
      STEP_VDIV: begin
        op  = OP_DIV;
        opa = num;
        opb = mean_source ? OPB_W'(cnt) : OPB_W'(nn_r);
      end
      STEP_VSQ:  begin op = OP_SQRT; opa = ACC_W'(var_r);                       end
      default:   begin op = OP_MUL;                                             end
    endcase
  end

  ssr_iter u_iter (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .op    (op),
    .a     (opa),
    .b     (opb),
    .done  (done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_source <= 1'b0;
      given_mean  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEAN_SOURCE: mean_source <= cfg_data[0];
        default:         given_mean  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      run_sum <= '0;
      run_sq  <= '0;
      lo_val  <= '0;
      hi_val  <= '0;
      lo_idx  <= '0;
      hi_idx  <= '0;
      cnt     <= '0;
      nz      <= 1'b0;
      ovf     <= 1'b0;
    end else if (cmd.accept) begin
      if (cnt < MAX_COUNT) begin
        if (cnt == '0 || sample < lo_val) begin
          lo_val <= sample;
          lo_idx <= cnt[11:0];
        end
        if (cnt == '0 || sample > hi_val) begin
          hi_val <= sample;
          hi_idx <= cnt[11:0];
        end
        run_sum <= run_sum + 28'(sample);
        run_sq  <= run_sq + 43'(sq_x);
        if (sample != '0) nz <= 1'b1;
        cnt <= cnt + 13'd1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      unique case (cmd.step)
        STEP_MEAN: mean_r <= run_sum[27] ? (~res[15:0] + 16'd1) : res[15:0];
        STEP_MSQ:  msq_r  <= res[31:0];
        STEP_RMS:  rms_r  <= res[15:0];
        STEP_NSQ:  t1     <= res;
        STEP_SS:   t2     <= res;
        STEP_NN:   nn_r   <= res[31:0];
        STEP_GS:   t2     <= res;
        STEP_GG:   nn_r   <= res[31:0];
        STEP_NGG:  t1     <= res;
        STEP_NUM:  num    <= num_w[ACC_W-1:0];
        STEP_VDIV: var_r  <= (res[ACC_W-1:32] != '0) ? 32'hFFFF_FFFF : res[31:0];
        STEP_VSQ:  std_r  <= res[15:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sum_total      <= run_sum;
      mean_value     <= mean_r;
      variance_value <= var_r;
      std_dev        <= std_r;
      rms_value      <= rms_r;
      min_value      <= lo_val;
      min_position   <= lo_idx;
      max_value      <= hi_val;
      max_position   <= hi_idx;
      all_zero       <= ~nz;
      element_count  <= cnt;
      overflow       <= ovf;
    end
  end

endmodule

// ----- sv/stream_statistics_reducer_unit.sv -----
// Top level of the stream statistics reducer.
// Samples are taken one per cycle while a set accumulates.
// After the last sample the finalize sequence runs on one shared iterative
// mul/div/sqrt unit while the input is stalled; its three divides are its longest operations.
// The result register lets a new set start while a result waits.
// Synchronous active-high reset clears the set state and both config registers.
module stream_statistics_reducer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               last_element,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [27:0] sum_total,
  output logic signed [15:0] mean_value,
  output logic [31:0]        variance_value,
  output logic [15:0]        std_dev,
  output logic [15:0]        rms_value,
  output logic signed [15:0] min_value,
  output logic [11:0]        min_position,
  output logic signed [15:0] max_value,
  output logic [11:0]        max_position,
  output logic               all_zero,
  output logic [12:0]        element_count,
  output logic               overflow,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import ssr_pkg::*;

  ssr_cmd_t cmd;
  ssr_sts_t sts;

  ssr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .last_element (last_element),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ssr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .sample         (sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sum_total      (sum_total),
    .mean_value     (mean_value),
    .variance_value (variance_value),
    .std_dev        (std_dev),
    .rms_value      (rms_value),
    .min_value      (min_value),
    .min_position   (min_position),
    .max_value      (max_value),
    .max_position   (max_position),
    .all_zero       (all_zero),
    .element_count  (element_count),
    .overflow       (overflow)
  );

endmodule
